// ===== src/rssi_parent_selector_macros.svh =====
// Assertion helpers for the file that carries checks.
`ifndef RSSI_PARENT_SELECTOR_MACROS_SVH
`define RSSI_PARENT_SELECTOR_MACROS_SVH

// Check on aclk, ignored while reset is held.
`define RPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on aclk that also holds through reset.
`define RPS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/rps_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rps_pkg
// Shared types and constants of the RSSI parent selector.
// ---------------------------------------------------------------------------
package rps_pkg;

    localparam int ADDR_W = 16;
    localparam int SUM_W  = 16;
    localparam int ENTRY_W = ADDR_W + SUM_W;

    localparam logic signed [SUM_W-1:0] NO_PATH = -16'sd1000;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 16'sh7fff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -16'sh8000;

    localparam logic [1:0] REG_IS_ROOT = 2'd0;

    typedef struct packed {
        logic [ADDR_W-1:0]       sender_addr;
        logic signed [SUM_W-1:0] advertised_path;
        logic signed [7:0]       link_rssi;
    } in_t;

    typedef struct packed {
        logic                    parent_valid;
        logic [ADDR_W-1:0]       parent_addr;
        logic signed [SUM_W-1:0] own_path_sum;
        logic                    table_full_drop;
    } out_t;

    typedef enum logic {
        SCAN_LOOKUP,
        SCAN_SELECT
    } scan_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEL,
        ST_DONE
    } rps_state_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       write_entry;
        logic       mark_drop;
        logic       commit;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic match_found;
        logic table_full;
        logic out_busy;
    } stat_t;

endpackage

// ===== src/rps_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rps_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module rps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rps_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rps_ctrl
// Sequencer: lookup scan, entry write or drop, parent scan (skipped on a root), result transfer.
// ---------------------------------------------------------------------------
module rps_ctrl
    import rps_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  m_ready,
    input  logic  is_root,
    input  stat_t stat,
    output cmd_t  cmd
);

    rps_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_LOOKUP;
                    state_next     = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (stat.scan_done) begin
                    if (!stat.match_found && stat.table_full) begin
                        cmd.mark_drop = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        cmd.write_entry = 1'b1;
                        if (!is_root) begin
                            // parent scan sees the entry written on this edge
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_SELECT;
                            state_next     = ST_SEL;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_SEL: begin
                if (stat.scan_done) begin
                    cmd.commit = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stat.out_busy || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rps_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rps_datapath
// Neighbor table, scan engine, parent registers and result register.
// ---------------------------------------------------------------------------
module rps_datapath
    import rps_pkg::*;
#(
    parameter int NEIGHBOR_SLOTS = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  in_t   s_data,
    input  logic  is_root,
    input  cmd_t  cmd,
    output stat_t stat,
    input  logic  m_ready,
    output logic  m_valid,
    output out_t  m_data
);

    localparam int IW = $clog2(NEIGHBOR_SLOTS);
    localparam int CW = $clog2(NEIGHBOR_SLOTS + 1);

    in_t in_reg;

    // fill count: slots are never freed, so they fill in arrival order
    logic [CW-1:0] count_reg, count_next;

    logic          scan_active_reg, scan_active_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    scan_mode_t    mode_reg, mode_next;

    logic          found_reg, found_next;
    logic [IW-1:0] slot_reg;
    logic          win_reg, win_next;
    logic signed [SUM_W-1:0] best_reg, best_next;
    logic [ADDR_W-1:0]       win_addr_reg, win_addr_next;

    logic                    flag_reg;
    logic [ADDR_W-1:0]       parent_reg;
    logic signed [SUM_W-1:0] path_reg;
    logic                    drop_reg;

    logic m_valid_reg, m_valid_next;
    out_t out_reg;

    logic [ENTRY_W-1:0]      rdata;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [SUM_W-1:0] rd_sum;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic [IW-1:0]           wr_slot;
    logic                    table_full;

    assign table_full = (count_reg == CW'(NEIGHBOR_SLOTS));
    assign rd_addr    = rdata[ENTRY_W-1:SUM_W];
    assign rd_sum     = $signed(rdata[SUM_W-1:0]);

    always_comb begin
        sum_wide = {in_reg.advertised_path[SUM_W-1], in_reg.advertised_path}
                 + {{(SUM_W-7){in_reg.link_rssi[7]}}, in_reg.link_rssi};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign wr_slot = found_reg ? slot_reg : count_reg[IW-1:0];

    always_comb begin
        count_next = count_reg;
        if (cmd.write_entry && !found_reg) begin
            count_next = count_reg + CW'(1);
        end
    end

    rps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NEIGHBOR_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.write_entry),
        .waddr (wr_slot),
        .wdata ({in_reg.sender_addr, sum_sat}),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    // scan engine: one read issued per cycle, its data arriving in the cycle after
    always_comb begin
        scan_active_next = scan_active_reg;
        rd_idx_next      = rd_idx_reg;
        rd_vld_next      = 1'b0;
        mode_next        = mode_reg;
        found_next       = found_reg;
        win_next         = win_reg;
        best_next        = best_reg;
        win_addr_next    = win_addr_reg;

        if (rd_vld_reg) begin
            if (mode_reg == SCAN_LOOKUP) begin
                if (!found_reg && rd_addr == in_reg.sender_addr) begin
                    found_next = 1'b1;
                end
            end else begin
                // ascending order with >= hands ties to the newest entry
                if (rd_sum < 0 && rd_sum > NO_PATH && (!win_reg || rd_sum >= best_reg)) begin
                    win_next      = 1'b1;
                    best_next     = rd_sum;
                    win_addr_next = rd_addr;
                end
            end
        end

        if (scan_active_reg) begin
            rd_vld_next = 1'b1;
            if (rd_idx_reg == IW'(count_reg - CW'(1))) begin
                scan_active_next = 1'b0;
            end else begin
                rd_idx_next = rd_idx_reg + IW'(1);
            end
        end

        if (cmd.scan_start) begin
            scan_active_next = (count_next != '0);
            rd_idx_next      = '0;
            rd_vld_next      = 1'b0;
            mode_next        = cmd.scan_mode;
            win_next         = 1'b0;
            if (cmd.scan_mode == SCAN_LOOKUP) begin
                found_next = 1'b0;
            end
        end
    end

    // slot of the data in flight is one behind the issue index, except at wrap
    // which never happens: the issue index holds on the last slot
    logic [IW-1:0] rd_idx_d_reg;
    always_ff @(posedge aclk) begin
        rd_idx_d_reg <= rd_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            scan_active_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            flag_reg        <= 1'b0;
            parent_reg      <= '0;
            path_reg        <= NO_PATH;
            m_valid_reg     <= 1'b0;
        end else begin
            count_reg       <= count_next;
            scan_active_reg <= scan_active_next;
            rd_vld_reg      <= rd_vld_next;
            m_valid_reg     <= m_valid_next;
            if (cmd.commit && win_reg) begin
                flag_reg   <= 1'b1;
                parent_reg <= win_addr_reg;
                path_reg   <= best_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        mode_reg     <= mode_next;
        found_reg    <= found_next;
        slot_reg     <= (rd_vld_reg && found_next && !found_reg) ? rd_idx_d_reg : slot_reg;
        win_reg      <= win_next;
        best_reg     <= best_next;
        win_addr_reg <= win_addr_next;
        if (cmd.load) begin
            in_reg   <= s_data;
            drop_reg <= 1'b0;
        end else if (cmd.mark_drop) begin
            drop_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            out_reg.parent_valid    <= flag_reg;
            out_reg.parent_addr     <= parent_reg;
            out_reg.own_path_sum    <= is_root ? '0 : path_reg;
            out_reg.table_full_drop <= drop_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign stat.scan_done   = !scan_active_reg && !rd_vld_reg;
    assign stat.match_found = found_reg;
    assign stat.table_full  = table_full;
    assign stat.out_busy    = m_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/rssi_parent_selector.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rssi_parent_selector
// Neighbor table with parent selection by largest negative path RSSI.
// ---------------------------------------------------------------------------
//   channel   ports              carries
//   input     s_valid/s_ready    one beacon: sender, advertised path, link RSSI
//   result    m_valid/m_ready    parent flag, parent address, path sum, drop
//   config    APB psel/penable   is_root, the same register at every paddr
//
// For each accepted beacon the block makes one pass over the table RAM to
// find the sender, one write, and one more pass to pick the parent, each
// pass one RAM read per cycle. A root node skips the second pass; a beacon
// dropped on a full table skips both the write and the second pass.
// Reset empties the table at once through the fill count.
// A result waits in the output register while the next beacon is taken;
// a stalled result holds the block after that beacon's scans.
// ---------------------------------------------------------------------------
`include "rssi_parent_selector_macros.svh"

module rssi_parent_selector
    import rps_pkg::*;
#(
    parameter int NEIGHBOR_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t cmd;
    stat_t stat;
    logic is_root_reg;

    // paddr is not decoded: every address writes and reads the one register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_root_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            is_root_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_IS_ROOT) ? {31'd0, is_root_reg} : {31'd0, is_root_reg};

    rps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .is_root (is_root_reg),
        .stat    (stat),
        .cmd     (cmd)
    );

    rps_datapath #(
        .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .is_root (is_root_reg),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    `RPS_ASSERT(a_one_item_at_a_time, s_valid && s_ready |=> !s_ready, "input taken during scan")
    `RPS_ASSERT(a_drop_only_when_full, m_valid && m_data.table_full_drop |-> stat.table_full, "drop reported with free slots")
    `RPS_ASSERT_ALWAYS(a_reset_clears_result, !aresetn |=> !m_valid, "result valid after reset")

endmodule

// ===== verif/rssi_parent_selector_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rssi_parent_selector_test
// Self-checking bench for the RSSI parent selector. A neighbor-table model
// predicts one result per accepted beacon. Directed beacons cover field
// extremes, saturation and ties; random traffic in root and non-root phases
// follows and runs into table overflow, with random idling on both channels.
// ---------------------------------------------------------------------------
module rssi_parent_selector_test
    import rps_pkg::*;
();

    localparam int SLOTS         = 16;
    localparam int TABLE_LATENCY = 2 * SLOTS + 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 300;

    // Neighbor table model: tracks entries and parent choice, queues results.
    class parent_table_model;
        bit          used [SLOTS];
        logic [15:0] sender [SLOTS];
        int          path_sum [SLOTS];
        int          filled;
        logic [15:0] parent;
        bit          parent_flag;
        int          best_sum;
        bit          root_mode;
        int          errors;
        out_t        awaited_results [$];

        function new();
            foreach (used[i]) used[i] = 0;
            filled      = 0;
            parent      = '0;
            parent_flag = 0;
            best_sum    = NO_PATH;
            root_mode   = 0;
            errors      = 0;
        endfunction

        function void note_beacon(in_t b);
            int   slot;
            int   free_slot;
            int   sum;
            int   top;
            int   win;
            bit   drop;
            out_t res;
            slot      = -1;
            free_slot = -1;
            drop      = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i]) begin
                    if (slot < 0 && sender[i] == b.sender_addr) slot = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (slot < 0) begin
                if (free_slot < 0) begin
                    drop = 1;
                end else begin
                    slot         = free_slot;
                    used[slot]   = 1;
                    sender[slot] = b.sender_addr;
                    filled++;
                end
            end
            if (!drop) begin
                sum = $signed(b.advertised_path) + $signed(b.link_rssi);
                if (sum > SUM_MAX) sum = SUM_MAX;
                if (sum < SUM_MIN) sum = SUM_MIN;
                path_sum[slot] = sum;
                if (!root_mode) begin
                    // scan newest first with a strict compare so ties go to the newest
                    top = NO_PATH;
                    win = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (used[i] && path_sum[i] > top && path_sum[i] < 0) begin
                            top = path_sum[i];
                            win = i;
                        end
                    end
                    if (win >= 0) begin
                        parent      = sender[win];
                        parent_flag = 1;
                        best_sum    = top;
                    end
                end
            end
            res.parent_valid    = parent_flag;
            res.parent_addr     = parent;
            res.own_path_sum    = root_mode ? '0 : best_sum[15:0];
            res.table_full_drop = drop;
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: result with no beacon pending, expected none actual %h",
                         $time, got);
            end else begin
                want = awaited_results.pop_front();
                compare_field("parent_valid", want.parent_valid, got.parent_valid);
                compare_field("parent_addr", want.parent_addr, got.parent_addr);
                compare_field("own_path_sum", $signed(want.own_path_sum),
                              $signed(got.own_path_sum));
                compare_field("table_full_drop", want.table_full_drop, got.table_full_drop);
            end
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    parent_table_model sb = new();
    bit  burst;
    bit  hold_req;
    int  stall;
    int  cycles;

    rssi_parent_selector #(
        .NEIGHBOR_SLOTS(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, then draw the stall for the next one.
    initial begin
        m_ready = 0;
        stall   = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
                stall = burst ? 0 : $urandom_range(0, 8);
            end
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 0;
            end
            if (stall > 0) begin
                m_ready <= 0;
                stall--;
            end else begin
                m_ready <= 1;
            end
        end
    end

    function automatic in_t beacon(logic [15:0] addr, int path, int rssi);
        in_t b;
        b.sender_addr     = addr;
        b.advertised_path = path[15:0];
        b.link_rssi       = rssi[7:0];
        return b;
    endfunction

    function automatic in_t random_beacon();
        logic [15:0] addr;
        int          path;
        int          rssi;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70 && sb.filled > 0) addr = sb.sender[$urandom_range(0, sb.filled - 1)];
        else addr = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        rssi = $urandom_range(0, 255) - 128;
        if (pick < 75) begin
            path = $urandom_range(0, 1400) - 1200;
        end else if (pick < 90) begin
            path = $urandom_range(0, 65535) - 32768;
        end else begin
            // push toward the saturation limits
            path = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 100)
                                        : -32768 + $urandom_range(0, 100);
        end
        return beacon(addr, path, rssi);
    endfunction

    task automatic send_beacon(input in_t b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= b;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_beacon(b);
    endtask

    task automatic wait_drained();
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (TABLE_LATENCY) @(posedge aclk);
    endtask

    // Write is_root while idle, then read it back.
    task automatic write_is_root(input bit root);
        wait_drained();
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= REG_IS_ROOT;
        pwdata  <= {31'b0, root};
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        sb.root_mode = root;
        psel    <= 0;
        penable <= 0;
        @(posedge aclk);
        psel    <= 1;
        pwrite  <= 0;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] != root) begin
            sb.errors++;
            $display("%0t: is_root readback mismatch, expected %0d actual %0d",
                     $time, root, prdata[0]);
        end
        psel    <= 0;
        penable <= 0;
        @(posedge aclk);
    endtask

    initial begin
        int phase_items [5];
        bit phase_root [5];
        phase_items = '{600, 300, 500, 300, 300};
        phase_root  = '{0, 1, 0, 1, 0};
        aresetn  = 0;
        s_valid  = 0;
        s_data   = '0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        burst    = 0;
        hold_req = 0;
        cycles   = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        write_is_root(0);
        send_beacon(beacon(16'h0000, 0, 0));
        send_beacon(beacon(16'hFFFF, -32768, -128));   // saturate low
        send_beacon(beacon(16'h1234, 32767, 127));     // saturate high
        send_beacon(beacon(16'h0001, -1000, 0));       // at the no-path bound, never chosen
        send_beacon(beacon(16'h0002, -1000, 1));       // just above the bound
        send_beacon(beacon(16'h0003, 0, -1));
        send_beacon(beacon(16'h0004, -2, 1));          // tie, newest wins
        send_beacon(beacon(16'h0003, -500, 0));
        send_beacon(beacon(16'h0004, 4, 1));
        send_beacon(beacon(16'h0003, -2000, 0));
        send_beacon(beacon(16'h0002, 0, 0));           // nothing qualifies, keep parent
        send_beacon(beacon(16'hFFFF, 32767, -128));
        send_beacon(beacon(16'h5A5A, -32768, 127));
        s_valid <= 0;
        write_is_root(1);
        send_beacon(beacon(16'h0001, -10, 0));         // stored, no selection
        s_valid <= 0;
        write_is_root(0);
        send_beacon(beacon(16'h0000, -20, -3));
        s_valid <= 0;

        for (int p = 0; p < 5; p++) begin
            write_is_root(phase_root[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (p == 0 && k == 100) hold_req = 1;
                if (p == 0 && k == 300) begin
                    // hold the sender until every result is back
                    s_valid <= 0;
                    wait_drained();
                end
                burst = ((k / 64) % 4 == 1);
                send_beacon(random_beacon());
            end
            s_valid <= 0;
            burst = 0;
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
